// File: hw/rtl/d96i32_pkg.sv
// ============================================================================
// d96i32_pkg
// Shared types and constants for the 96-bit decimal to int32 converter.
// ============================================================================
package d96i32_pkg;

    localparam int MANT_W    = 96;
    localparam int CELL_W    = 8;
    localparam int NUM_CELLS = MANT_W / CELL_W;
    localparam int REM_W     = 4;
    localparam int CUR_W     = REM_W + CELL_W;
    localparam int WORD_W    = 32;
    localparam int SCALE_W   = 8;
    localparam int STEP_W    = 5;
    localparam int MAX_SCALE = 28;

    // floor(x / 10) == (x * 1639) >> 14 for every x below 2560
    localparam int RECIP_MUL   = 1639;
    localparam int RECIP_SHIFT = 14;
    localparam int RECIP_W     = 11;
    localparam int PROD_W      = CUR_W + RECIP_W;

    localparam logic [WORD_W-1:0] SIGN_BIT      = 32'h8000_0000;
    localparam logic [WORD_W-1:0] RESERVED_MASK = 32'h7F00_FFFF;
    localparam logic [WORD_W-1:0] POS_LIMIT     = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] NEG_LIMIT     = 32'h8000_0000;

    // Remainder hand-off between neighboring cells
    typedef struct packed {
        logic             act;
        logic [REM_W-1:0] rem;
    } link_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

endpackage

// File: hw/rtl/decimal96_to_int32.sv
// ============================================================================
// decimal96_to_int32
// Truncate a 96-bit scaled decimal toward zero into a signed 32-bit integer.
// ============================================================================
// One transaction at a time: a new decimal is accepted only in IDLE, after the
//   previous result is posted; a malformed decimal or a zero scale runs no divide
//   steps, and an output stall holds the conversion in RUN until the slot frees.
// Each divide-by-ten ripples down the twelve byte cells, one per cycle; steps overlap.
// Reset (rst_n, async, active low) clears the state machine, the cell
//   handshake bits and the output valid; data registers are not reset.
module decimal96_to_int32 (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         mant_low,
    input  logic [31:0]         mant_mid,
    input  logic [31:0]         mant_high,
    input  logic [31:0]         flag_word,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  int_value,
    output logic                error
);

    localparam int NC = d96i32_pkg::NUM_CELLS;
    localparam int CW = d96i32_pkg::CELL_W;
    localparam int WW = d96i32_pkg::WORD_W;

    d96i32_pkg::state_t state_reg, state_next;

    logic [d96i32_pkg::STEP_W-1:0]  steps_reg, steps_next;
    logic                           bad_reg, bad_next;
    logic                           neg_reg, neg_next;
    logic                           out_valid_reg, out_valid_next;
    logic [WW-1:0]                  value_reg, value_next;
    logic                           err_reg, err_next;

    logic                           in_fire;
    logic                           load;
    logic [d96i32_pkg::MANT_W-1:0]  load_mant;
    logic [d96i32_pkg::MANT_W-1:0]  mant_cur;
    logic [d96i32_pkg::SCALE_W-1:0] scale;
    logic                           malformed;
    logic                           any_act;
    logic                           finish;
    logic                           slot_free;
    logic                           res_err;
    logic [WW-1:0]                  res_value;
    logic [WW-1:0]                  low_word;

    d96i32_pkg::link_t chain [NC+1];

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    assign in_ready  = (state_reg == d96i32_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign load      = in_fire;
    assign load_mant = {mant_high, mant_mid, mant_low};
    assign scale     = flag_word[16 +: d96i32_pkg::SCALE_W];
    assign malformed = ((flag_word & d96i32_pkg::RESERVED_MASK) != '0) ||
                       (scale > d96i32_pkg::SCALE_W'(d96i32_pkg::MAX_SCALE));

    // ------------------------------------------------------------------
    // Cell row: the top cell takes a fresh divide step every cycle while
    // steps remain; each lower cell takes the step in the cycle after its neighbor.
    // ------------------------------------------------------------------
    assign chain[NC].act = (state_reg == d96i32_pkg::ST_RUN) && (steps_reg != '0);
    assign chain[NC].rem = '0;

    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        d96i32_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (load),
            .load_byte (load_mant[i*CW +: CW]),
            .link_in   (chain[i+1]),
            .link_out  (chain[i]),
            .byte_val  (mant_cur[i*CW +: CW])
        );
    end

    always_comb
    begin
        any_act = 1'b0;
        for (int i = 0; i < NC; i++)
        begin
            any_act = any_act | chain[i].act;
        end
    end

    // ------------------------------------------------------------------
    // Range check on the truncated mantissa
    // ------------------------------------------------------------------
    assign low_word = mant_cur[WW-1:0];

    always_comb
    begin
        res_err   = 1'b0;
        res_value = '0;
        if (bad_reg || (mant_cur[d96i32_pkg::MANT_W-1:WW] != '0))
        begin
            res_err = 1'b1;
        end
        else if (neg_reg)
        begin
            if (low_word > d96i32_pkg::NEG_LIMIT)
            begin
                res_err = 1'b1;
            end
            else
            begin
                res_value = WW'(0) - low_word;
            end
        end
        else
        begin
            if (low_word > d96i32_pkg::POS_LIMIT)
            begin
                res_err = 1'b1;
            end
            else
            begin
                res_value = low_word;
            end
        end
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    assign slot_free = !out_valid_reg || out_ready;
    assign finish    = (state_reg == d96i32_pkg::ST_RUN) && (steps_reg == '0) &&
                       !any_act && slot_free;

    always_comb
    begin
        state_next     = state_reg;
        steps_next     = steps_reg;
        bad_next       = bad_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        err_next       = err_reg;

        // drop the result once the consumer takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            d96i32_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    bad_next   = malformed;
                    neg_next   = flag_word[WW-1];
                    steps_next = malformed ? '0 : scale[d96i32_pkg::STEP_W-1:0];
                    state_next = d96i32_pkg::ST_RUN;
                end
            end
            d96i32_pkg::ST_RUN:
            begin
                if (steps_reg != '0)
                begin
                    steps_next = steps_reg - d96i32_pkg::STEP_W'(1);
                end
                // hold in RUN until the row drains and the output slot frees
                if (finish)
                begin
                    out_valid_next = 1'b1;
                    value_next     = res_value;
                    err_next       = res_err;
                    state_next     = d96i32_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = d96i32_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= d96i32_pkg::ST_IDLE;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bad_reg   <= bad_next;
        neg_reg   <= neg_next;
        value_reg <= value_next;
        err_reg   <= err_next;
    end

    assign out_valid = out_valid_reg;
    assign int_value = signed'(value_reg);
    assign error     = err_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_rise_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == d96i32_pkg::ST_RUN))
        else $error("result appeared without a conversion in progress");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error) |-> (int_value == '0))
        else $error("error result carries a nonzero value");

    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (state_reg == d96i32_pkg::ST_IDLE) && out_valid)
        else $error("finished conversion did not post a result");

    a_no_steps_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == d96i32_pkg::ST_IDLE) |-> (steps_reg == '0) && !any_act)
        else $error("divider row busy while idle");

endmodule

// File: hw/rtl/d96i32_cell.sv
// ============================================================================
// d96i32_cell
// One byte of the mantissa: divide by ten with the incoming remainder.
// ============================================================================
module d96i32_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic [d96i32_pkg::CELL_W-1:0]   load_byte,
    input  d96i32_pkg::link_t               link_in,
    output d96i32_pkg::link_t               link_out,
    output logic [d96i32_pkg::CELL_W-1:0]   byte_val
);

    logic [d96i32_pkg::CELL_W-1:0] byte_reg;
    logic [d96i32_pkg::CELL_W-1:0] byte_next;
    d96i32_pkg::link_t             link_reg;
    d96i32_pkg::link_t             link_next;
    logic [d96i32_pkg::CUR_W-1:0]  cur;
    logic [d96i32_pkg::PROD_W-1:0] prod;
    logic [d96i32_pkg::CELL_W-1:0] quo;
    logic [d96i32_pkg::CUR_W-1:0]  rem_full;

    assign cur      = {link_in.rem, byte_reg};
    assign prod     = d96i32_pkg::PROD_W'(cur) *
                      d96i32_pkg::PROD_W'(d96i32_pkg::RECIP_MUL);
    assign quo      = prod[d96i32_pkg::RECIP_SHIFT +: d96i32_pkg::CELL_W];
    assign rem_full = cur - d96i32_pkg::CUR_W'(quo) * d96i32_pkg::CUR_W'(10);

    always_comb
    begin
        byte_next     = byte_reg;
        link_next.act = 1'b0;
        link_next.rem = link_reg.rem;
        if (load)
        begin
            byte_next = load_byte;
        end
        else if (link_in.act)
        begin
            // take one quotient byte, pass the remainder down
            byte_next     = quo;
            link_next.act = 1'b1;
            link_next.rem = rem_full[d96i32_pkg::REM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign link_out = link_reg;
    assign byte_val = byte_reg;

endmodule
